// ===== hw/rtl/chmp_pkg.sv =====
// Package with the shared types and constants of the chmod mode token parser.
`default_nettype none
package chmp_pkg;

  localparam int ModeW = 12;
  localparam int PermW = 9;
  localparam int CharW = 8;

  localparam logic [PermW-1:0] UMASK_RESET = 9'o022;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SET    = 2'd3;

  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_R     = 8'h72;
  localparam logic [CharW-1:0] CH_W     = 8'h77;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_U     = 8'h75;
  localparam logic [CharW-1:0] CH_G     = 8'h67;
  localparam logic [CharW-1:0] CH_O     = 8'h6F;
  localparam logic [CharW-1:0] CH_A     = 8'h61;

  localparam logic [PermW-1:0] PERM_R    = 9'o444;
  localparam logic [PermW-1:0] PERM_W    = 9'o222;
  localparam logic [PermW-1:0] PERM_X    = 9'o111;
  localparam logic [PermW-1:0] WHO_U     = 9'o700;
  localparam logic [PermW-1:0] WHO_G     = 9'o070;
  localparam logic [PermW-1:0] WHO_O     = 9'o007;
  localparam logic [PermW-1:0] WHO_ALL   = 9'o777;

  typedef struct packed {
    logic             fire;
    logic             last;
    logic [CharW-1:0] ch;
  } step_t;

  typedef struct packed {
    logic             octal_valid;
    logic             negative_sign;
    logic [ModeW-1:0] octal_value;
  } num_result_t;

  typedef struct packed {
    logic             symbolic_error;
    logic [PermW-1:0] add_bits;
    logic [PermW-1:0] remove_bits;
  } sym_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chmp_tok_if.sv =====
// Interface of the input channel that carries token characters.
`default_nettype none
interface chmp_tok_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ch;
  logic        last;
  logic [11:0] current_mode;

  modport source (output valid, output ch, output last, output current_mode, input ready);
  modport sink (input valid, input ch, input last, input current_mode, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/chmp_res_if.sv =====
// Interface of the output channel that carries parse results.
`default_nettype none
interface chmp_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] result_mode;
  logic        status;

  modport source (output valid, output result_mode, output status, input ready);
  modport sink (input valid, input result_mode, input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/chmp_numeric.sv =====
// Numeric reading of the token: optional sign followed by octal digits.
`default_nettype none
module chmp_numeric (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire chmp_pkg::step_t      step,
  output chmp_pkg::num_result_t     result
);
  import chmp_pkg::*;

  logic             char_position;
  logic             negative_sign;
  logic [ModeW-1:0] octal_value;
  logic             octal_valid;
  logic             octal_stopped;

  logic             negative_sign_next;
  logic [ModeW-1:0] octal_value_next;
  logic             octal_valid_next;
  logic             octal_stopped_next;
  logic             is_digit;

  assign is_digit = (step.ch[7:3] == 5'b00110);

  always_comb begin
    negative_sign_next = negative_sign;
    octal_value_next   = octal_value;
    octal_valid_next   = octal_valid;
    octal_stopped_next = octal_stopped;
    if (!octal_stopped) begin
      if (!char_position && (step.ch == CH_PLUS || step.ch == CH_MINUS)) begin
        negative_sign_next = (step.ch == CH_MINUS);
      end else if (is_digit) begin
        octal_value_next = {octal_value[ModeW-4:0], step.ch[2:0]};
        octal_valid_next = 1'b1;
      end else begin
        octal_stopped_next = 1'b1;
      end
    end
  end

  assign result.octal_valid   = octal_valid_next;
  assign result.negative_sign = negative_sign_next;
  assign result.octal_value   = octal_value_next;

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      char_position <= 1'b0;
      negative_sign <= 1'b0;
      octal_value   <= '0;
      octal_valid   <= 1'b0;
      octal_stopped <= 1'b0;
    end else if (step.fire) begin
      char_position <= 1'b1;
      negative_sign <= negative_sign_next;
      octal_value   <= octal_value_next;
      octal_valid   <= octal_valid_next;
      octal_stopped <= octal_stopped_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/chmp_symbolic.sv =====
// Symbolic reading of the token: clauses of who letters, an operator and permissions.
`default_nettype none
module chmp_symbolic (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire chmp_pkg::step_t           step,
  input  wire logic [chmp_pkg::PermW-1:0] umask,
  output chmp_pkg::sym_result_t          result
);
  import chmp_pkg::*;

  logic [1:0]       clause_operator;
  logic [PermW-1:0] who_bits;
  logic [PermW-1:0] perm_bits;
  logic [PermW-1:0] add_bits;
  logic [PermW-1:0] remove_bits;
  logic             symbolic_error;

  logic [1:0]       op_a;
  logic [PermW-1:0] who_a;
  logic [PermW-1:0] perm_a;
  logic             err_a;
  logic             do_close;
  logic [PermW-1:0] nb;

  logic [1:0]       clause_operator_next;
  logic [PermW-1:0] who_bits_next;
  logic [PermW-1:0] perm_bits_next;
  logic [PermW-1:0] add_bits_next;
  logic [PermW-1:0] remove_bits_next;
  logic             symbolic_error_next;

  // Character step, without the clause close that a comma or the final character performs.
  always_comb begin
    op_a   = clause_operator;
    who_a  = who_bits;
    perm_a = perm_bits;
    err_a  = symbolic_error;
    if (!symbolic_error && step.ch != CH_COMMA) begin
      if (clause_operator != OP_NONE) begin
        case (step.ch)
          CH_R:    perm_a = perm_bits | PERM_R;
          CH_W:    perm_a = perm_bits | PERM_W;
          CH_X:    perm_a = perm_bits | PERM_X;
          default: err_a  = 1'b1;
        endcase
      end else begin
        case (step.ch)
          CH_PLUS, CH_MINUS, CH_EQUAL: begin
            op_a = (step.ch == CH_PLUS)  ? OP_ADD :
                   (step.ch == CH_MINUS) ? OP_REMOVE : OP_SET;
            if (who_bits == '0) begin
              who_a = ~umask & WHO_ALL;
            end
          end
          CH_U:    who_a = who_bits | WHO_U;
          CH_G:    who_a = who_bits | WHO_G;
          CH_O:    who_a = who_bits | WHO_O;
          CH_A:    who_a = WHO_ALL;
          default: err_a = 1'b1;
        endcase
      end
    end
  end

  assign do_close = !err_a && (step.ch == CH_COMMA || step.last);
  assign nb       = perm_a & who_a;

  always_comb begin
    clause_operator_next = op_a;
    who_bits_next        = who_a;
    perm_bits_next       = perm_a;
    add_bits_next        = add_bits;
    remove_bits_next     = remove_bits;
    symbolic_error_next  = err_a;
    if (do_close) begin
      clause_operator_next = OP_NONE;
      who_bits_next        = '0;
      perm_bits_next       = '0;
      case (op_a)
        OP_ADD: begin
          add_bits_next    = add_bits | nb;
          remove_bits_next = remove_bits & ~nb;
        end
        OP_REMOVE: begin
          remove_bits_next = remove_bits | nb;
          add_bits_next    = add_bits & ~nb;
        end
        OP_SET: begin
          add_bits_next    = add_bits | nb;
          remove_bits_next = (remove_bits & ~nb) | (~nb & who_a);
        end
        default: symbolic_error_next = 1'b1;
      endcase
    end
  end

  assign result.symbolic_error = symbolic_error_next;
  assign result.add_bits       = add_bits_next;
  assign result.remove_bits    = remove_bits_next;

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      clause_operator <= OP_NONE;
      who_bits        <= '0;
      perm_bits       <= '0;
      add_bits        <= '0;
      remove_bits     <= '0;
      symbolic_error  <= 1'b0;
    end else if (step.fire) begin
      clause_operator <= clause_operator_next;
      who_bits        <= who_bits_next;
      perm_bits       <= perm_bits_next;
      add_bits        <= add_bits_next;
      remove_bits     <= remove_bits_next;
      symbolic_error  <= symbolic_error_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/chmod_mode_string_parser_top.sv =====
// Top level of the chmod mode token parser.
// The tok channel takes one character of a mode token per transfer; last marks the
// final character, and current_mode is sampled with it. The res channel gives one
// transfer per token, result_mode and status, after the final character.
// A character goes into an input register and is folded into the numeric and
// symbolic parse state from there; a character that is not final is folded in the
// following cycle. A folded final character loads the result and raises res.valid.
// One character is taken every cycle unless a final one waits. The result register
// parts the two sides: characters are still taken while a result waits, and only
// a final character waits in the input register until the result register is free.
// umask_we writes umask_wdata into the umask register; do this only while idle.
// Reset clears the parse state, empties both registers and sets the umask to 022.
`default_nettype none
module chmod_mode_string_parser_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       umask_we,
  input  wire logic [chmp_pkg::PermW-1:0] umask_wdata,
  chmp_tok_if.sink                        tok,
  chmp_res_if.source                      res
);
  import chmp_pkg::*;

  logic [PermW-1:0] umask;
  logic             s1_valid;
  logic [CharW-1:0] s1_ch;
  logic             s1_last;
  logic [ModeW-1:0] s1_mode;
  logic             s1_fire;
  logic             out_free;
  logic             res_valid;
  logic [ModeW-1:0] res_mode;
  logic             res_status;
  logic [ModeW-1:0] mode_next;
  logic             status_next;
  step_t            step;
  num_result_t      num;
  sym_result_t      sym;

  assign out_free  = !res_valid || res.ready;
  assign s1_fire   = s1_valid && (!s1_last || out_free);
  assign tok.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      umask <= UMASK_RESET;
    end else if (umask_we) begin
      umask <= umask_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tok.ready) begin
      s1_valid <= tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok.valid && tok.ready) begin
      s1_ch   <= tok.ch;
      s1_last <= tok.last;
      s1_mode <= tok.current_mode;
    end
  end

  assign step.fire = s1_fire;
  assign step.last = s1_last;
  assign step.ch   = s1_ch;

  chmp_numeric u_numeric (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .result (num)
  );

  chmp_symbolic u_symbolic (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .umask  (umask),
    .result (sym)
  );

  always_comb begin
    if (num.octal_valid) begin
      mode_next   = num.negative_sign ? (ModeW'(0) - num.octal_value) : num.octal_value;
      status_next = 1'b0;
    end else if (sym.symbolic_error) begin
      mode_next   = '0;
      status_next = 1'b1;
    end else begin
      mode_next   = {s1_mode[ModeW-1:PermW],
                     (s1_mode[PermW-1:0] & ~sym.remove_bits) | sym.add_bits};
      status_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res_mode   <= mode_next;
      res_status <= status_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.result_mode = res_mode;
  assign res.status      = res_status;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> tok.ready)
    else $error("Input register empty but tok.ready low.");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid && s1_last))
    else $error("Result appeared without a final character.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status) |-> (res_mode == '0))
    else $error("Invalid status with a nonzero mode.");

endmodule
`default_nettype wire
